@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the skinning engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define LBS_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that a condition never occurs.
`define LBS_NEVER(lbl, ck, rst_n, cond, msg) \
	`LBS_ASSERT(lbl, ck, rst_n, !(cond), msg)

`endif

@@ hw/rtl/lbs_pkg.sv @@
// Shared types and constants of the linear blend skinning engine.
package lbs_pkg;

	localparam int BONES_DEF = 64;
	localparam int FRAC_DEF  = 16;

	localparam int S_DATA_W = 152;
	localparam int M_DATA_W = 96;
	localparam int VAL_W    = 32;
	localparam int ACC_W    = 48;
	localparam int SUM_W    = 82;
	localparam int MUL_B_W  = 25;
	localparam int PROD_W   = 57;
	localparam int HALF_W   = 24;
	localparam int Q_W      = 32;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_PAL_WR,
		OP_PAL_RD,
		OP_MAC_MUL,
		OP_MAC_ADD,
		OP_XF_LO,
		OP_XF_HI,
		OP_XF_ADD,
		OP_XF_W,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] elem;
		logic [1:0] lane;
	} dp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic in_range;
		logic is_last;
		logic zero_w;
		logic out_full;
	} dp_stat_t;

endpackage

@@ hw/rtl/lbs_ctrl.sv @@
// Sequencing state machine of the skinning engine.
module lbs_ctrl
	import lbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_WR, ST_RD, ST_MUL, ST_ADD, ST_XLO, ST_XHI,
		ST_XADD, ST_XW, ST_DCHK, ST_DINIT, ST_DSTEP, ST_DEND, ST_OUT
	} state_t;

	localparam logic [3:0] LAST_ELEM = 4'd15;
	localparam logic [4:0] LAST_STEP = 5'd31;
	localparam logic [1:0] LAST_LANE = 2'd2;
	localparam logic [1:0] LAST_COL  = 2'd3;
	localparam logic [1:0] ROW_Z     = 2'd2;

	state_t     state_q;
	logic [3:0] elem_q;
	logic [4:0] step_q;
	logic [1:0] lane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_q  <= '0;
			step_q  <= '0;
			lane_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					elem_q <= '0;
					if (stat.is_load) state_q <= stat.in_range ? ST_WR : ST_IDLE;
					else if (stat.in_range) state_q <= ST_RD;
					else if (stat.is_last) state_q <= ST_XLO;
					else state_q <= ST_IDLE;
				end
				ST_WR: state_q <= ST_IDLE;
				ST_RD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					elem_q <= elem_q + 4'd1;
					if (elem_q == LAST_ELEM) state_q <= stat.is_last ? ST_XLO : ST_IDLE;
					else if (elem_q[1:0] == LAST_COL) state_q <= ST_RD;
					else state_q <= ST_MUL;
				end
				ST_XLO: state_q <= ST_XHI;
				ST_XHI: state_q <= ST_XADD;
				ST_XADD: begin
					elem_q <= elem_q + 4'd1;
					if (elem_q[3:2] == ROW_Z && elem_q[1:0] == LAST_COL) state_q <= ST_XW;
					else state_q <= ST_XLO;
				end
				ST_XW: begin
					elem_q <= elem_q + 4'd1;
					if (elem_q == LAST_ELEM) state_q <= ST_DCHK;
				end
				ST_DCHK: begin
					lane_q  <= '0;
					state_q <= stat.zero_w ? ST_OUT : ST_DINIT;
				end
				ST_DINIT: begin
					step_q  <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					step_q <= step_q + 5'd1;
					if (step_q == LAST_STEP) state_q <= ST_DEND;
				end
				ST_DEND: begin
					lane_q  <= lane_q + 2'd1;
					state_q <= (lane_q == LAST_LANE) ? ST_OUT : ST_DINIT;
				end
				ST_OUT: begin
					if (!stat.out_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd.elem = elem_q;
		cmd.lane = lane_q;
		case (state_q)
			ST_IDLE:  cmd.op = s_tvalid ? OP_CAPTURE : OP_NONE;
			ST_WR:    cmd.op = OP_PAL_WR;
			ST_RD:    cmd.op = OP_PAL_RD;
			ST_MUL:   cmd.op = OP_MAC_MUL;
			ST_ADD:   cmd.op = OP_MAC_ADD;
			ST_XLO:   cmd.op = OP_XF_LO;
			ST_XHI:   cmd.op = OP_XF_HI;
			ST_XADD:  cmd.op = OP_XF_ADD;
			ST_XW:    cmd.op = OP_XF_W;
			ST_DINIT: cmd.op = OP_DIV_INIT;
			ST_DSTEP: cmd.op = OP_DIV_STEP;
			ST_DEND:  cmd.op = OP_DIV_END;
			ST_OUT:   cmd.op = stat.out_full ? OP_NONE : OP_OUT;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ hw/rtl/lbs_dpath.sv @@
// Datapath of the skinning engine: palette, accumulator, transform and divider.
module lbs_dpath
	import lbs_pkg::*;
#(
	parameter int BONES     = BONES_DEF,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tuser,
	input  logic                s_tlast,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser
);

	localparam int AW = $clog2(BONES * 4);
	localparam int NW = SUM_W + FRAC_BITS;
	localparam int CW = SUM_W + Q_W;
	localparam int RW = SUM_W + 1;
	localparam logic [16:0] W_ONE = 17'd32768;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [Q_W-1:0] LIM_POS = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] LIM_NEG = {1'b1, {(Q_W-1){1'b0}}};

	logic                 is_load_q, last_q;
	logic [5:0]           bone_q;
	logic [1:0]           row_q;
	logic [16:0]          w_q;
	logic [4*VAL_W-1:0]   val_q;
	logic [4*VAL_W-1:0]   pal_mem [BONES*4];
	logic [4*VAL_W-1:0]   rd_q;
	logic [AW+7:0]        addr_wide;
	logic [AW-1:0]        pal_addr;
	logic signed [ACC_W-1:0]  acc_q [16];
	logic signed [ACC_W-1:0]  acc_new;
	logic signed [ACC_W:0]    mac_sum;
	logic signed [VAL_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]  s_q [4];
	logic                 in_range;
	logic                 zero_w;
	logic signed [SUM_W-1:0] num_sel;
	logic [SUM_W-1:0]     mag_n, mag_d;
	logic [NW-1:0]        n_full;
	logic [SUM_W-1:0]     rem_q, d_q;
	logic [Q_W-1:0]       nlo_q, q_q;
	logic                 neg_q, ovf_q;
	logic [RW-1:0]        rem2;
	logic                 q_bit;
	logic [Q_W-1:0]       lim, q_sat;
	logic [VAL_W-1:0]     res_q [3];
	logic                 m_tvalid_q, m_tuser_q;
	logic [M_DATA_W-1:0]  m_tdata_q;

	assign in_range = (32'(bone_q) < BONES);
	assign zero_w   = (s_q[3] == '0);

	assign stat.is_load  = is_load_q;
	assign stat.in_range = in_range;
	assign stat.is_last  = last_q;
	assign stat.zero_w   = zero_w;
	assign stat.out_full = m_tvalid_q & ~m_tready;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			is_load_q <= ~s_tuser;
			bone_q    <= s_tdata[5:0];
			row_q     <= s_tdata[7:6];
			w_q       <= (s_tdata[23:8] > W_ONE[15:0]) ? W_ONE : {1'b0, s_tdata[23:8]};
			val_q     <= s_tdata[151:24];
			last_q    <= s_tlast;
		end
	end

	assign addr_wide = (AW+8)'({bone_q, (cmd.op == OP_PAL_WR) ? row_q : cmd.elem[3:2]});
	assign pal_addr  = addr_wide[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PAL_WR && in_range) pal_mem[pal_addr] <= val_q;
		if (cmd.op == OP_PAL_RD) rd_q <= pal_mem[pal_addr];
	end

	always_comb begin
		case (cmd.op)
			OP_MAC_MUL: begin
				mul_a = rd_q[cmd.elem[1:0]*VAL_W +: VAL_W];
				mul_b = MUL_B_W'(w_q);
			end
			OP_XF_LO: begin
				mul_a = val_q[cmd.elem[3:2]*VAL_W +: VAL_W];
				mul_b = {1'b0, acc_q[0][HALF_W-1:0]};
			end
			OP_XF_HI: begin
				mul_a = val_q[cmd.elem[3:2]*VAL_W +: VAL_W];
				mul_b = {acc_q[0][ACC_W-1], acc_q[0][ACC_W-1:HALF_W]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MAC_MUL || cmd.op == OP_XF_LO || cmd.op == OP_XF_HI)
			prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign mac_sum = (ACC_W+1)'(acc_q[0]) + (ACC_W+1)'(prod_s1 >>> 15);

	always_comb begin
		if (cmd.op == OP_MAC_ADD) begin
			if (mac_sum[ACC_W] != mac_sum[ACC_W-1])
				acc_new = mac_sum[ACC_W] ? ACC_MIN : ACC_MAX;
			else
				acc_new = mac_sum[ACC_W-1:0];
		end else begin
			acc_new = acc_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) acc_q[i] <= '0;
		end else if (cmd.op == OP_OUT) begin
			for (int i = 0; i < 16; i++) acc_q[i] <= '0;
		end else if (cmd.op == OP_MAC_ADD || cmd.op == OP_XF_ADD || cmd.op == OP_XF_W) begin
			for (int i = 0; i < 15; i++) acc_q[i] <= acc_q[i+1];
			acc_q[15] <= acc_new;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				for (int i = 0; i < 4; i++) s_q[i] <= '0;
			end
			OP_XF_HI: s_q[cmd.elem[1:0]] <= s_q[cmd.elem[1:0]] + SUM_W'(prod_s1);
			OP_XF_ADD: begin
				s_q[cmd.elem[1:0]] <= s_q[cmd.elem[1:0]] + (SUM_W'(prod_s1) <<< HALF_W);
			end
			OP_XF_W: begin
				s_q[cmd.elem[1:0]] <= s_q[cmd.elem[1:0]] + (SUM_W'(acc_q[0]) <<< FRAC_BITS);
			end
			default: ;
		endcase
	end

	assign num_sel = s_q[cmd.lane];
	assign mag_n   = num_sel[SUM_W-1] ? SUM_W'(-num_sel) : num_sel;
	assign mag_d   = s_q[3][SUM_W-1] ? SUM_W'(-s_q[3]) : s_q[3];
	assign n_full  = NW'(mag_n) << FRAC_BITS;
	assign rem2    = {rem_q, nlo_q[Q_W-1]};
	assign q_bit   = (rem2 >= {1'b0, d_q});
	assign lim     = neg_q ? LIM_NEG : LIM_POS;
	assign q_sat   = (ovf_q || q_q > lim) ? lim : q_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DIV_INIT: begin
				d_q   <= mag_d;
				neg_q <= num_sel[SUM_W-1] ^ s_q[3][SUM_W-1];
				ovf_q <= (CW'(n_full) >= {mag_d, {Q_W{1'b0}}});
				rem_q <= SUM_W'(n_full >> Q_W);
				nlo_q <= n_full[Q_W-1:0];
				q_q   <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= q_bit ? SUM_W'(rem2 - {1'b0, d_q}) : rem2[SUM_W-1:0];
				nlo_q <= {nlo_q[Q_W-2:0], 1'b0};
				q_q   <= {q_q[Q_W-2:0], q_bit};
			end
			OP_DIV_END: res_q[cmd.lane] <= neg_q ? -q_sat : q_sat;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			m_tdata_q <= zero_w ? '0 : {res_q[2], res_q[1], res_q[0]};
			m_tuser_q <= zero_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ hw/rtl/linear_blend_skinning.sv @@
// Top level of the linear blend skinning engine.
// One transaction is taken at a time. An influence on a bone in the palette
// is worked by one shared multiplier that goes through the sixteen matrix
// elements; an influence on a bone outside the palette skips that work. An
// influence marked last then runs the row-vector transform on the same
// multiplier, then three 32-step restoring divisions (skipped when w is
// zero), and loads the output register, which may hold a result while the
// next transaction is already being accepted.
module linear_blend_skinning
	import lbs_pkg::*;
#(
	parameter int BONES     = BONES_DEF,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // bone, row, weight, val_a, val_b, val_c, val_d
	input  logic                s_tuser,  // cmd
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // out_x, out_y, out_z
	output logic                m_tuser   // zero_w
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lbs_dpath #(
		.BONES     (BONES),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ hw/rtl/lbs_checker.sv @@
// Port-level checker of the skinning engine and its bind to the top level.
`include "assert_macros.svh"

module lbs_checker
	import lbs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic                s_tuser,
	input logic                s_tlast,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser
);

	`LBS_ASSERT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`LBS_ASSERT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second transaction taken while busy")
	`LBS_ASSERT(a_rise_after_busy, clk, arst_n, $rose(m_tvalid) |-> !$past(s_tready), "result without work")
	`LBS_NEVER(a_zero_w_data, clk, arst_n, m_tvalid && m_tuser && m_tdata != '0, "zero w with nonzero coordinates")

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);

@@ test/tb_linear_blend_skinning.sv @@
// Self-checking testbench for the linear blend skinning engine.
`timescale 1ns / 1ps

module tb_linear_blend_skinning;
	import lbs_pkg::*;

	localparam int NBONES = BONES_DEF;
	localparam int FRAC   = FRAC_DEF;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_INFL = 1'b1;
	localparam longint ACC_HI = 64'sd140737488355327;
	localparam longint ACC_LO = -ACC_HI - 1;

	typedef struct {
		logic        cmd;
		logic [5:0]  bone;
		logic [1:0]  row;
		logic [15:0] weight;
		logic [31:0] va, vb, vc, vd;
		logic        last;
	} skin_item_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic        zw;
	} vertex_out_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	linear_blend_skinning u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	skin_item_t  pending_items[$];
	vertex_out_t expected_vertices[$];
	logic signed [31:0] palette_copy[NBONES*16];
	logic signed [47:0] blend_acc[16];
	int errors, n_loads, n_infl, n_vertices, n_zero_w, gap, stall;
	bit drained;

	function automatic int draw_wait();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom();
			3: return 32'(signed'($urandom_range(0, 2 ** 20)) - 2 ** 19);
			default: return 32'(signed'($urandom_range(0, 2 ** 19)) - 2 ** 18);
		endcase
	endfunction

	// Updates the mirrored palette and accumulator; returns 1 when a vertex completes.
	function automatic bit skin_predict(skin_item_t it, output vertex_out_t res);
		logic signed [127:0] pos[4], sum[4], pk, ak, num, q;
		longint prod, nxt;
		logic [15:0] w;
		logic [31:0] outs[3];
		if (it.cmd == CMD_LOAD) begin
			palette_copy[it.bone*16 + it.row*4 + 0] = it.va;
			palette_copy[it.bone*16 + it.row*4 + 1] = it.vb;
			palette_copy[it.bone*16 + it.row*4 + 2] = it.vc;
			palette_copy[it.bone*16 + it.row*4 + 3] = it.vd;
			return 0;
		end
		w = (it.weight > 16'd32768) ? 16'd32768 : it.weight;
		for (int k = 0; k < 16; k++) begin
			prod = longint'(palette_copy[it.bone*16 + k]) * longint'({1'b0, w});
			nxt = longint'(blend_acc[k]) + (prod >>> 15);
			if (nxt > ACC_HI) nxt = ACC_HI;
			if (nxt < ACC_LO) nxt = ACC_LO;
			blend_acc[k] = nxt[47:0];
		end
		if (!it.last)
			return 0;
		pos[0] = signed'(it.va);
		pos[1] = signed'(it.vb);
		pos[2] = signed'(it.vc);
		pos[3] = 128'sd1 <<< FRAC;
		for (int j = 0; j < 4; j++) begin
			sum[j] = 0;
			for (int k = 0; k < 4; k++) begin
				pk = pos[k];
				ak = blend_acc[k*4 + j];
				sum[j] = sum[j] + pk * ak;
			end
		end
		res.zw = (sum[3] == 0);
		for (int j = 0; j < 3; j++) begin
			if (res.zw) begin
				outs[j] = 0;
			end else begin
				num = sum[j] <<< FRAC;
				q = num / sum[3];
				if (q > 128'sh7FFF_FFFF) q = 128'sh7FFF_FFFF;
				if (q < -128'sh8000_0000) q = -128'sh8000_0000;
				outs[j] = q[31:0];
			end
		end
		res.x = outs[0];
		res.y = outs[1];
		res.z = outs[2];
		for (int k = 0; k < 16; k++) blend_acc[k] = 0;
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		skin_item_t cur;
		vertex_out_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			s_tlast  <= 1'b0;
			gap = 0;
			for (int k = 0; k < 16; k++) blend_acc[k] = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				cur.cmd = s_tuser; cur.last = s_tlast;
				{cur.vd, cur.vc, cur.vb, cur.va, cur.weight, cur.row, cur.bone} = s_tdata;
				if (cur.cmd == CMD_LOAD) n_loads++; else n_infl++;
				if (skin_predict(cur, res)) begin
					expected_vertices.insert(expected_vertices.size(), res);
					n_vertices++;
					if (res.zw) n_zero_w++;
				end
				gap = draw_wait();
			end
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur = pending_items.pop_front();
					s_tdata  <= {cur.vd, cur.vc, cur.vb, cur.va, cur.weight, cur.row, cur.bone};
					s_tuser  <= cur.cmd;
					s_tlast  <= cur.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		vertex_out_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
		end else if (m_tvalid && m_tready) begin
			if (expected_vertices.size() == 0) begin
				$error("unexpected result transaction x=%h y=%h z=%h zero_w=%b",
					m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
				errors++;
			end else begin
				e = expected_vertices.pop_front();
				if (m_tdata[31:0] !== e.x) begin
					$error("out_x expected %h actual %h", e.x, m_tdata[31:0]); errors++;
				end
				if (m_tdata[63:32] !== e.y) begin
					$error("out_y expected %h actual %h", e.y, m_tdata[63:32]); errors++;
				end
				if (m_tdata[95:64] !== e.z) begin
					$error("out_z expected %h actual %h", e.z, m_tdata[95:64]); errors++;
				end
				if (m_tuser !== e.zw) begin
					$error("zero_w expected %b actual %b", e.zw, m_tuser); errors++;
				end
			end
			stall = draw_wait();
			m_tready <= (stall == 0);
		end else if (stall > 0) begin
			stall--;
			m_tready <= (stall == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic skin_item_t mk(logic cmd, int bone, int row, logic [15:0] w,
			logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d, logic last);
		skin_item_t it;
		it.cmd = cmd; it.bone = 6'(bone); it.row = 2'(row); it.weight = w;
		it.va = a; it.vb = b; it.vc = c; it.vd = d; it.last = last;
		return it;
	endfunction

	task automatic queue_item(skin_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic add_vertex(int n);
		for (int i = 0; i < n; i++)
			queue_item(mk(CMD_INFL, $urandom_range(0, NBONES - 1), $urandom(),
				$urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768)),
				rand_val(), rand_val(), rand_val(), $urandom(), i == n - 1));
	endtask

	initial begin
		arst_n = 1'b0;
		errors = 0; n_loads = 0; n_infl = 0; n_vertices = 0; n_zero_w = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Every palette entry is written before any influence reads it.
		for (int b = 0; b < NBONES; b++)
			for (int r = 0; r < 4; r++)
				queue_item(mk(CMD_LOAD, b, r, 16'($urandom()), rand_val(), rand_val(),
					rand_val(), (r == 3) ? 32'h0001_0000 : rand_val(),
					1'($urandom_range(0, 1))));
		for (int r = 0; r < 4; r++) begin
			queue_item(mk(CMD_LOAD, 0, r, 16'd0, r == 0 ? 32'h10000 : 0,
				r == 1 ? 32'h10000 : 0, r == 2 ? 32'h10000 : 0, r == 3 ? 32'h10000 : 0, 1'b1));
			queue_item(mk(CMD_LOAD, 1, r, 16'hFFFF, 0, 0, 0, 0, 1'b1));
			queue_item(mk(CMD_LOAD, 63, r, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000,
				32'h7FFF_FFFF, r == 3 ? 32'h8000_0000 : 32'h0000_0001, 1'b0));
		end
		queue_item(mk(CMD_INFL, 0, 0, 16'd32768, 32'h7FFF_FFFF, 32'h8000_0000,
			0, 0, 1'b1));
		queue_item(mk(CMD_INFL, 1, 3, 16'd32768, 32'h10000, 0, 0, 0, 1'b1));
		queue_item(mk(CMD_INFL, 0, 0, 16'hFFFF, 32'h30000, 32'hFFFF0000, 5, 0, 1'b1));
		queue_item(mk(CMD_INFL, 0, 0, 16'd0, 1, 2, 3, 0, 1'b1));
		queue_item(mk(CMD_INFL, 63, 0, 16'd32768, 0, 0, 0, 0, 1'b0));
		queue_item(mk(CMD_INFL, 63, 0, 16'd32768, 0, 0, 0, 0, 1'b0));
		queue_item(mk(CMD_INFL, 63, 1, 16'd32768, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
		queue_item(mk(CMD_INFL, 0, 0, 16'd16384, 0, 0, 0, 0, 1'b0));
		queue_item(mk(CMD_INFL, 5, 2, 16'd16384, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 1'b1));

		while (pending_items.size() < 1400) begin
			if ($urandom_range(0, 9) < 2)
				queue_item(mk(CMD_LOAD, $urandom_range(0, NBONES - 1), $urandom(),
					16'($urandom()), rand_val(), rand_val(), rand_val(),
					$urandom_range(0, 4) == 0 ? 32'h0 : rand_val(),
					1'($urandom_range(0, 1))));
			else
				add_vertex($urandom_range(1, 4));
		end

		drained = 0;
		while (!drained) begin
			@(posedge clk);
			drained = pending_items.size() == 0 && !s_tvalid && expected_vertices.size() == 0;
		end
		repeat (300) @(posedge clk);
		$display("Covered %0d palette loads and %0d influences, %0d vertices checked",
			n_loads, n_infl, n_vertices);
		$display("of which %0d had a zero homogeneous w", n_zero_w);
		if (errors == 0 && expected_vertices.size() == 0)
			$display("tb_linear_blend_skinning OK");
		else
			$display("tb_linear_blend_skinning NOT OK");
		$finish;
	end

	initial begin
		#100ms;
		$display("Timeout with %0d results still expected", expected_vertices.size());
		$display("tb_linear_blend_skinning NOT OK");
		$finish;
	end

endmodule
